// File: design/tdpt_pkg.sv
// Shared types and constants for the trial division prime test.
package tdpt_pkg;

    // First trial divisor and its square.
    localparam int unsigned FIRST_DIVISOR = 3;
    localparam int unsigned FIRST_SQUARE  = 9;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;        // capture a new number, reset divisor to three
        logic div_start;   // begin a remainder computation
        logic next_div;    // advance divisor by one and update its square
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic invalid;     // number is zero or negative
        logic one_or_two;  // number is one or two
        logic even;        // number is even
        logic sq_over;     // divisor squared exceeds the number
        logic div_done;    // remainder unit is idle
        logic rem_zero;    // last remainder was zero
    } t_sts;

endpackage

// File: design/tdpt_dp.sv
// Datapath: number register, divisor and square tracking, bit-serial remainder unit.
module tdpt_dp #(
    parameter int NUMBER_WIDTH = 32
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic [NUMBER_WIDTH-1:0] i_number,
    input  tdpt_pkg::t_cmd          i_cmd,
    output tdpt_pkg::t_sts          o_sts
);

    localparam int DW = NUMBER_WIDTH / 2 + 1;  // divisor width
    localparam int SW = NUMBER_WIDTH + 1;      // square width
    localparam int QW = NUMBER_WIDTH - 1;      // magnitude bits of a valid number
    localparam int CW = $clog2(NUMBER_WIDTH);  // step counter width

    logic [NUMBER_WIDTH-1:0] r_num;
    logic [DW-1:0]           r_div;
    logic [SW-1:0]           r_sq;
    logic [QW-1:0]           r_shift;
    logic [DW-1:0]           r_rem;
    logic [CW-1:0]           r_cnt;

    logic [DW:0]             w_trial;
    logic                    w_ge;
    logic [DW:0]             w_diff;

    // One restoring step: bring down the next dividend bit and subtract if it fits.
    assign w_trial = {r_rem, r_shift[QW-1]};
    assign w_diff  = w_trial - {1'b0, r_div};
    assign w_ge    = (w_trial >= {1'b0, r_div});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            if (i_cmd.div_start) begin
                r_cnt <= CW'(QW);
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_num <= i_number;
            r_div <= DW'(tdpt_pkg::FIRST_DIVISOR);
            r_sq  <= SW'(tdpt_pkg::FIRST_SQUARE);
        end else if (i_cmd.next_div) begin
            r_div <= r_div + 1'b1;
            r_sq  <= r_sq + SW'({r_div, 1'b1});  // (d+1)^2 = d^2 + 2d + 1
        end
        if (i_cmd.div_start) begin
            r_shift <= r_num[QW-1:0];
            r_rem   <= '0;
        end else if (r_cnt != '0) begin
            r_shift <= {r_shift[QW-2:0], 1'b0};
            r_rem   <= w_ge ? w_diff[DW-1:0] : w_trial[DW-1:0];
        end
    end

    always_comb begin
        o_sts.invalid    = (r_num == '0) || r_num[NUMBER_WIDTH-1];
        o_sts.one_or_two = (r_num == NUMBER_WIDTH'(1)) || (r_num == NUMBER_WIDTH'(2));
        o_sts.even       = ~r_num[0];
        o_sts.sq_over    = (r_sq > {1'b0, r_num});
        o_sts.div_done   = (r_cnt == '0);
        o_sts.rem_zero   = (r_rem == '0);
    end

endmodule

// File: design/tdpt_ctrl.sv
// Controller: sequences classification, trial divisions and result delivery.
module tdpt_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output logic           o_status,
    output logic           o_composite,
    output tdpt_pkg::t_cmd o_cmd,
    input  tdpt_pkg::t_sts i_sts
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CHECK,
        S_DIV,
        S_OUT
    } t_state;

    t_state r_state, n_state;
    logic   r_status, n_status;
    logic   r_composite, n_composite;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_OUT);
    assign o_status    = r_status;
    assign o_composite = r_composite;

    always_comb begin
        n_state     = r_state;
        n_status    = r_status;
        n_composite = r_composite;
        o_cmd       = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CHECK;
                end
            end
            S_CHECK: begin
                n_status    = 1'b0;
                n_composite = 1'b0;
                if (i_sts.invalid) begin
                    n_status = 1'b1;
                    n_state  = S_OUT;
                end else if (i_sts.one_or_two) begin
                    n_state = S_OUT;
                end else if (i_sts.even) begin
                    n_composite = 1'b1;
                    n_state     = S_OUT;
                end else if (i_sts.sq_over) begin
                    n_state = S_OUT;
                end else begin
                    o_cmd.div_start = 1'b1;
                    n_state         = S_DIV;
                end
            end
            S_DIV: begin
                if (i_sts.div_done) begin
                    if (i_sts.rem_zero) begin
                        n_composite = 1'b1;
                        n_state     = S_OUT;
                    end else begin
                        o_cmd.next_div = 1'b1;
                        n_state        = S_CHECK;
                    end
                end
            end
            S_OUT: begin
                if (i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_status    <= 1'b0;
            r_composite <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_status    <= n_status;
            r_composite <= n_composite;
        end
    end

endmodule

// File: design/trial_division_prime_test.sv
// Top level of the trial division prime test: stream ports, controller and datapath.
//
// Takes one signed number per transaction and returns one result telling whether it is
// composite (tuser flags zero or negative input as invalid). One item is processed at a
// time. Zero, negative, one, two and even inputs pass through the accept state, the
// classify state and the output state. An odd input n is divided by d = 3, 4, ... while
// d*d <= n; each divisor passes through the classify state and a remainder computation
// in the bit-serial remainder unit before the result is offered and taken.
module trial_division_prime_test #(
    parameter int NUMBER_WIDTH = 32
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    // Bits from the lowest: number (NUMBER_WIDTH bits), zero padding to whole bytes.
    input  logic [((NUMBER_WIDTH + 7) / 8) * 8-1:0] s_axis_tdata,
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    // Bits from the lowest: composite, zero padding.
    output logic [7:0]                             m_axis_tdata,
    // Bits from the lowest: status (1 = invalid input).
    output logic [0:0]                             m_axis_tuser
);

    tdpt_pkg::t_cmd w_cmd;
    tdpt_pkg::t_sts w_sts;
    logic           w_status;
    logic           w_composite;

    tdpt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_status    (w_status),
        .o_composite (w_composite),
        .o_cmd       (w_cmd),
        .i_sts       (w_sts)
    );

    tdpt_dp #(
        .NUMBER_WIDTH (NUMBER_WIDTH)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_number (s_axis_tdata[NUMBER_WIDTH-1:0]),
        .i_cmd    (w_cmd),
        .o_sts    (w_sts)
    );

    assign m_axis_tdata = {7'b0, w_composite};
    assign m_axis_tuser = w_status;

endmodule
